// File: rtl/core/bmd_pkg.sv
`timescale 1ns / 1ps

package bmd_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MSG_HANDLES_DEF = 64;

    // request modes
    localparam logic [2:0] MODE_POST_BACK  = 3'd0;
    localparam logic [2:0] MODE_POST_FRONT = 3'd1;
    localparam logic [2:0] MODE_ACCEPT     = 3'd2;
    localparam logic [2:0] MODE_PEEK       = 3'd3;
    localparam logic [2:0] MODE_REL_CHECK  = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_BUSY  = 3'd4;

    // configuration register indexes
    localparam logic CFG_CAPACITY  = 1'b0;
    localparam logic CFG_UNLIMITED = 1'b1;

    localparam logic [4:0] CAPACITY_RST = 5'd16;

    // one result, highest field first in tdata
    typedef struct packed {
        logic [4:0] free_slots;
        logic [4:0] queued;
        logic       msg_present;
        logic [5:0] msg_out;
        logic [2:0] status;
    } t_result;

endpackage

// File: rtl/core/bmd_ram.sv
`timescale 1ns / 1ps

module bmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/bounded_message_deque.sv
`timescale 1ns / 1ps
// Bounded message deque: ring of handles plus one on-list mark per handle.
// A request is taken in the idle state and its result is registered at the end
// of the execute state, which holds while the output is stalled. No new request
// is taken until then; the slot and mark memories are read when a request is
// taken and written back in the execute state. Reset: synchronous, active low;
// a clearing pass then zeroes the mark memory, no request is taken during it.

module bounded_message_deque #(
    parameter int QUEUE_DEPTH = bmd_pkg::QUEUE_DEPTH_DEF,
    parameter int MSG_HANDLES = bmd_pkg::MSG_HANDLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // mode[2:0], msg_id[8:3], zero fill
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // status[2:0], msg_out[8:3], msg_present[9],
                                     // queued[14:10], free_slots[19:15], zero fill
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index, // 0 capacity, 1 unlimited
    input  logic [4:0]  i_cfg_data
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;    // slot index
    localparam int CW = $clog2(QUEUE_DEPTH + 1);                         // count
    localparam int XW = (CW > 5) ? CW : 5;                               // limit compare
    localparam int HW = (MSG_HANDLES > 1) ? $clog2(MSG_HANDLES) : 1;    // handle

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // control state
    t_state              r_state, n_state;
    logic [HW-1:0]       r_clr_addr, n_clr_addr;
    logic [AW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;
    logic                r_out_valid, n_out_valid;
    logic [4:0]          r_capacity, n_capacity;
    logic                r_unlimited, n_unlimited;
    // payload
    logic [2:0]          r_mode, n_mode;
    logic [HW-1:0]       r_id, n_id;
    bmd_pkg::t_result    r_out, n_out;

    // handle wrap table: incoming 6-bit handle modulo MSG_HANDLES
    logic [HW-1:0] w_id_map [64];
    for (genvar k = 0; k < 64; k++) begin : g_id_map
        assign w_id_map[k] = HW'(k % MSG_HANDLES);
    end

    // memory ports
    logic          w_slot_we, w_mark_we, w_rd_en;
    logic [AW-1:0] w_slot_waddr;
    logic [HW-1:0] w_mark_waddr, w_mark_raddr;
    logic          w_mark_wdata;
    logic [HW-1:0] w_slot_rdata;
    logic          w_mark_rdata;

    bmd_ram #(
        .WIDTH (HW),
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_slot_we),
        .i_wr_addr (w_slot_waddr),
        .i_wr_data (r_id),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (w_slot_rdata)
    );

    bmd_ram #(
        .WIDTH (1),
        .DEPTH (MSG_HANDLES)
    ) u_mark_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mark_we),
        .i_wr_addr (w_mark_waddr),
        .i_wr_data (w_mark_wdata),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_mark_raddr),
        .o_rd_data (w_mark_rdata)
    );

    // effective limit: capacity saturated at depth, or depth when unlimited
    logic [XW-1:0] w_cap_x;
    logic [CW-1:0] w_limit;
    assign w_cap_x = XW'(r_capacity);
    assign w_limit = (r_unlimited || (w_cap_x > XW'(QUEUE_DEPTH))) ?
                     CW'(QUEUE_DEPTH) : CW'(w_cap_x);

    // ring positions
    logic [AW:0]   w_back_sum;
    logic [AW-1:0] w_back_pos, w_front_pos, w_next_head;
    assign w_back_sum  = {1'b0, r_head} + (AW+1)'(r_count);
    assign w_back_pos  = (w_back_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                         AW'(w_back_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(w_back_sum);
    assign w_front_pos = (r_head == '0) ? AW'(QUEUE_DEPTH - 1) : r_head - AW'(1);
    assign w_next_head = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);

    logic w_in_acc, w_exec_done, w_full, w_empty;
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_rd_en     = w_in_acc;
    assign w_mark_raddr = w_id_map[i_s_tdata[8:3]];
    // execute finishes once the output register can take the result
    assign w_exec_done = (r_state == S_EXEC) && (!r_out_valid || i_m_tready);
    assign w_full      = (r_count >= w_limit);
    assign w_empty     = (r_count == '0);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_head       = r_head;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_capacity   = r_capacity;
        n_unlimited  = r_unlimited;
        n_mode       = r_mode;
        n_id         = r_id;
        n_out        = r_out;
        w_slot_we    = 1'b0;
        w_slot_waddr = w_back_pos;
        w_mark_we    = 1'b0;
        w_mark_waddr = r_id;
        w_mark_wdata = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                bmd_pkg::CFG_CAPACITY:  n_capacity  = i_cfg_data;
                bmd_pkg::CFG_UNLIMITED: n_unlimited = i_cfg_data[0];
                default: ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                w_mark_we    = 1'b1;
                w_mark_waddr = r_clr_addr;
                w_mark_wdata = 1'b0;
                n_clr_addr   = r_clr_addr + HW'(1);
                if (r_clr_addr == HW'(MSG_HANDLES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_mode  = i_s_tdata[2:0];
                    n_id    = w_mark_raddr;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // memory read data is valid now and holds while stalled
                n_out.status      = bmd_pkg::ST_OK;
                n_out.msg_out     = '0;
                n_out.msg_present = 1'b0;
                case (r_mode)
                    bmd_pkg::MODE_POST_BACK, bmd_pkg::MODE_POST_FRONT: begin
                        if (w_full) begin
                            n_out.status = bmd_pkg::ST_FULL;
                        end else if (w_mark_rdata) begin
                            n_out.status = bmd_pkg::ST_DUP;
                        end else begin
                            w_slot_we    = w_exec_done;
                            w_mark_we    = w_exec_done;
                            w_mark_waddr = r_id;
                            w_mark_wdata = 1'b1;
                            n_count      = r_count + CW'(1);
                            if (r_mode == bmd_pkg::MODE_POST_FRONT) begin
                                w_slot_waddr = w_front_pos;
                                n_head       = w_front_pos;
                            end
                        end
                    end
                    bmd_pkg::MODE_ACCEPT, bmd_pkg::MODE_PEEK: begin
                        if (w_empty) begin
                            n_out.status = bmd_pkg::ST_EMPTY;
                        end else begin
                            n_out.msg_out     = 6'(w_slot_rdata);
                            n_out.msg_present = 1'b1;
                            if (r_mode == bmd_pkg::MODE_ACCEPT) begin
                                w_mark_we    = w_exec_done;
                                w_mark_waddr = w_slot_rdata;
                                w_mark_wdata = 1'b0;
                                n_head       = w_next_head;
                                n_count      = r_count - CW'(1);
                            end
                        end
                    end
                    bmd_pkg::MODE_REL_CHECK: begin
                        if (w_mark_rdata) begin
                            n_out.status = bmd_pkg::ST_BUSY;
                        end
                    end
                    default: ;  // unused modes: no change
                endcase
                n_out.queued     = 5'(n_count);
                n_out.free_slots = (n_count >= w_limit) ? 5'd0 : 5'(w_limit - n_count);

                if (w_exec_done) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    // stalled on the output: hold everything
                    n_head  = r_head;
                    n_count = r_count;
                    n_out   = r_out;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_capacity  <= bmd_pkg::CAPACITY_RST;
            r_unlimited <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_capacity  <= n_capacity;
            r_unlimited <= n_unlimited;
            r_mode      <= n_mode;
            r_id        <= n_id;
            r_out       <= n_out;
        end
    end

    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {4'b0, r_out};
    assign o_cfg_ready = 1'b1;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Message deque testbench: requests go in on the slave stream, results are
// checked on the master stream against a local model of the ring, the
// on-list marks and the configured limit.
module testbench;

    localparam int RING_SLOTS = bmd_pkg::QUEUE_DEPTH_DEF;
    localparam int HANDLES    = bmd_pkg::MSG_HANDLES_DEF;
    localparam int PHASE_LEN  = 125;
    localparam int SETTLE_CYC = 6;   // drain margin after the last result

    // one request: mode in the low bits, handle above
    typedef struct packed {
        logic [5:0] msg_id;
        logic [2:0] mode;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;     // mode[2:0], msg_id[8:3], zero fill
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;          // status[2:0], msg_out[8:3], msg_present[9],
                                     // queued[14:10], free_slots[19:15], zero fill
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = bmd_pkg::CFG_CAPACITY;
    logic [4:0]  i_cfg_data = '0;

    bounded_message_deque i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Model of the box
    // ------------------------------------------------------------------
    logic [4:0] box_capacity = bmd_pkg::CAPACITY_RST;
    logic       box_unlimited = 1'b0;
    logic [5:0] ring [RING_SLOTS];
    logic [3:0] box_head = '0;
    logic [4:0] box_count = '0;
    bit         on_list [HANDLES];

    t_request          request_backlog [$];   // waiting for the driver
    bmd_pkg::t_result  due_results [$];       // predicted, not yet seen on the output
    int       requests_made = 0;
    int       results_seen = 0;
    int       mismatch_count = 0;
    logic     req_taken = 1'b0;

    // Apply one request to the model; returns the result the box must give.
    function automatic bmd_pkg::t_result deque_predict(t_request r);
        bmd_pkg::t_result res;
        logic [4:0] limit;
        logic [5:0] head_msg;
        res = '0;
        res.status = bmd_pkg::ST_OK;
        // capacity above the ring size saturates; unlimited uses the ring size
        limit = (box_unlimited || box_capacity > RING_SLOTS) ? 5'(RING_SLOTS) : box_capacity;
        case (r.mode)
            bmd_pkg::MODE_POST_BACK, bmd_pkg::MODE_POST_FRONT: begin
                // full wins over duplicate
                if (box_count >= limit) begin
                    res.status = bmd_pkg::ST_FULL;
                end else if (on_list[r.msg_id]) begin
                    res.status = bmd_pkg::ST_DUP;
                end else begin
                    if (r.mode == bmd_pkg::MODE_POST_BACK) begin
                        ring[box_head + box_count[3:0]] = r.msg_id;
                    end else begin
                        box_head = box_head - 4'd1;
                        ring[box_head] = r.msg_id;
                    end
                    on_list[r.msg_id] = 1'b1;
                    box_count = box_count + 5'd1;
                end
            end
            bmd_pkg::MODE_ACCEPT, bmd_pkg::MODE_PEEK: begin
                if (box_count == 0) begin
                    res.status = bmd_pkg::ST_EMPTY;
                end else begin
                    head_msg = ring[box_head];
                    res.msg_out = head_msg;
                    res.msg_present = 1'b1;
                    if (r.mode == bmd_pkg::MODE_ACCEPT) begin
                        on_list[head_msg] = 1'b0;
                        box_head = box_head + 4'd1;
                        box_count = box_count - 5'd1;
                    end
                end
            end
            bmd_pkg::MODE_REL_CHECK: begin
                if (on_list[r.msg_id])
                    res.status = bmd_pkg::ST_BUSY;
            end
            default: ;   // undefined modes leave everything alone
        endcase
        res.queued = box_count;
        // capacity lowered under the count: no negative free space
        res.free_slots = (box_count >= limit) ? 5'd0 : limit - box_count;
        return res;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bmd_pkg::t_result want;
        bmd_pkg::t_result got;
        if (!i_rst_n) begin
            box_capacity = bmd_pkg::CAPACITY_RST;
            box_unlimited = 1'b0;
            box_head = '0;
            box_count = '0;
            for (int h = 0; h < HANDLES; h++)
                on_list[h] = 1'b0;
            req_taken <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bmd_pkg::CFG_CAPACITY)
                    box_capacity = i_cfg_data;
                else
                    box_unlimited = i_cfg_data[0];
            end
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[19:0];
                if (due_results.size() == 0) begin
                    $display("%0t: result %h expected none, got one", $time, o_m_tdata);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("msg_out", want.msg_out, got.msg_out);
                    compare_field("msg_present", want.msg_present, got.msg_present);
                    compare_field("queued", want.queued, got.queued);
                    compare_field("free_slots", want.free_slots, got.free_slots);
                    results_seen++;
                end
            end
            if (i_s_tvalid && o_s_tready)
                due_results.push_back(deque_predict(t_request'(i_s_tdata[8:0])));
            req_taken <= i_s_tvalid && o_s_tready;
        end
    end

    // ------------------------------------------------------------------
    // Request driver: bursts with random gaps, changes on the falling edge
    // ------------------------------------------------------------------
    int       tx_burst_left = 0;
    int       tx_gap_left = 0;
    t_request tx_next;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || req_taken) begin
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
                tx_next = request_backlog.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {7'b0, tx_next};
                if (tx_burst_left > 0) begin
                    tx_burst_left--;
                end else begin
                    // new burst; about a third of the bursts get a gap after their first request
                    tx_burst_left = $urandom_range(30);
                    tx_gap_left = ($urandom_range(2) == 0) ? $urandom_range(1, 8) : 0;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: switches between a few stall styles
    // ------------------------------------------------------------------
    int       rx_style = 0;
    int       rx_left = 0;
    int       rx_stall = 0;
    int       rx_cyc = 0;
    logic     rx_ready;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = $urandom_range(3);
            rx_left = $urandom_range(50, 200);
        end
        rx_left--;
        rx_cyc++;
        case (rx_style)
            0: rx_ready = 1'b1;                      // no back-pressure
            1: rx_ready = $urandom_range(1);         // coin flip
            2: rx_ready = (rx_cyc % 7) > 2;          // fixed beat
            default: begin                           // rare long stalls
                if (rx_stall > 0) begin
                    rx_stall--;
                    rx_ready = 1'b0;
                end else begin
                    rx_ready = 1'b1;
                    if ($urandom_range(15) == 0)
                        rx_stall = $urandom_range(5, 20);
                end
            end
        endcase
        i_m_tready <= rx_ready;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_request(input logic [2:0] mode, input logic [5:0] msg_id);
        t_request r;
        r.mode = mode;
        r.msg_id = msg_id;
        request_backlog.push_back(r);
        requests_made++;
    endtask

    // wait until every request has its result, then let the pipe drain
    task automatic wait_idle;
        while (results_seen != requests_made)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random phase: chunks lean toward filling, draining or a mix, so the box
    // spends time both at its limit and empty
    task automatic run_phase(input logic [4:0] cap, input logic unl, input int n);
        int         lean;
        int         post_pct;
        int         roll;
        logic [2:0] mode;
        logic [5:0] msg_id;
        wait_idle();
        write_reg(bmd_pkg::CFG_CAPACITY, cap);
        write_reg(bmd_pkg::CFG_UNLIMITED, unl);
        lean = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 25 == 0)
                lean = $urandom_range(2);
            post_pct = (lean == 0) ? 70 : (lean == 1) ? 20 : 45;
            roll = $urandom_range(99);
            if (roll < post_pct) begin
                mode = ($urandom_range(2) == 0) ? bmd_pkg::MODE_POST_FRONT :
                                                  bmd_pkg::MODE_POST_BACK;
            end else if (roll < post_pct + (100 - post_pct) * 6 / 10) begin
                mode = bmd_pkg::MODE_ACCEPT;
            end else begin
                roll = $urandom_range(19);
                if (roll < 8)
                    mode = bmd_pkg::MODE_PEEK;
                else if (roll < 18)
                    mode = bmd_pkg::MODE_REL_CHECK;
                else
                    mode = 3'($urandom_range(5, 7));   // undefined
            end
            // a small pool of handles makes duplicates and busy checks common
            msg_id = ($urandom_range(3) == 0) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
            queue_request(mode, msg_id);
        end
    endtask

    logic [4:0] phase_cap [12] = '{5'd16, 5'd4, 5'd0, 5'd1, 5'd31, 5'd16,
                                   5'd0, 5'd8, 5'd20, 5'd2, 5'd16, 5'd12};
    logic       phase_unl [12] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                   1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, capacity 16, limited
        write_reg(bmd_pkg::CFG_CAPACITY, 5'd16);
        write_reg(bmd_pkg::CFG_UNLIMITED, 1'b0);
        queue_request(bmd_pkg::MODE_ACCEPT, 6'd0);       // empty box
        queue_request(bmd_pkg::MODE_PEEK, 6'd0);
        queue_request(bmd_pkg::MODE_REL_CHECK, 6'd63);   // not queued: success
        queue_request(bmd_pkg::MODE_POST_BACK, 6'd0);
        queue_request(bmd_pkg::MODE_POST_BACK, 6'd63);
        queue_request(bmd_pkg::MODE_POST_FRONT, 6'd42);
        queue_request(bmd_pkg::MODE_POST_BACK, 6'd63);   // already queued
        queue_request(bmd_pkg::MODE_REL_CHECK, 6'd63);   // busy
        queue_request(bmd_pkg::MODE_PEEK, 6'd0);
        queue_request(3'd5, 6'd63);             // undefined modes are ignored
        queue_request(3'd6, 6'd63);
        queue_request(3'd7, 6'd63);
        queue_request(bmd_pkg::MODE_ACCEPT, 6'd0);
        queue_request(bmd_pkg::MODE_ACCEPT, 6'd0);
        queue_request(bmd_pkg::MODE_ACCEPT, 6'd0);
        queue_request(bmd_pkg::MODE_ACCEPT, 6'd0);       // empty again

        // small capacity: full, and full reported ahead of duplicate
        wait_idle();
        write_reg(bmd_pkg::CFG_CAPACITY, 5'd2);
        queue_request(bmd_pkg::MODE_POST_BACK, 6'd1);
        queue_request(bmd_pkg::MODE_POST_FRONT, 6'd2);
        queue_request(bmd_pkg::MODE_POST_BACK, 6'd3);
        queue_request(bmd_pkg::MODE_POST_BACK, 6'd1);

        // capacity dropped under the count: contents stay, no free space
        wait_idle();
        write_reg(bmd_pkg::CFG_CAPACITY, 5'd0);
        queue_request(bmd_pkg::MODE_POST_BACK, 6'd9);
        queue_request(bmd_pkg::MODE_PEEK, 6'd0);
        queue_request(bmd_pkg::MODE_ACCEPT, 6'd0);
        queue_request(bmd_pkg::MODE_ACCEPT, 6'd0);

        for (int p = 0; p < 12; p++)
            run_phase(phase_cap[p], phase_unl[p], PHASE_LEN);

        wait_idle();
        repeat (10) @(negedge i_clk);   // catch any stray result
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // far beyond the slowest legal run
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
